// ===== design/hst_pkg.sv =====
// Shared types, constants and helpers for the HTML span tokenizer.
// Used by every module of the block; depends on nothing.
package hst_pkg;

  localparam int MAX_LINE = 4096;
  localparam int COL_W    = $clog2(MAX_LINE);
  localparam int LEN_W    = COL_W + 1;
  localparam int CH_W     = 16;
  localparam int RECS     = 3;
  localparam int RIDX_W   = 2;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_LINE - 1);

  localparam logic [CH_W-1:0] CH_NUL   = 16'h0000;
  localparam logic [CH_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CH_W-1:0] CH_BANG  = 16'h0021;
  localparam logic [CH_W-1:0] CH_AMP   = 16'h0026;
  localparam logic [CH_W-1:0] CH_DASH  = 16'h002D;
  localparam logic [CH_W-1:0] CH_SLASH = 16'h002F;
  localparam logic [CH_W-1:0] CH_SEMI  = 16'h003B;
  localparam logic [CH_W-1:0] CH_LT    = 16'h003C;
  localparam logic [CH_W-1:0] CH_EQ    = 16'h003D;
  localparam logic [CH_W-1:0] CH_GT    = 16'h003E;

  typedef enum logic [2:0] {
    MD_NORMAL  = 3'd0,
    MD_COMMENT = 3'd1,
    MD_TAG     = 3'd2,
    MD_ANAME   = 3'd3,
    MD_AVALUE  = 3'd4,
    MD_PREFIX  = 3'd5,
    MD_ENTITY  = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    CONS_ENTITY  = 3'd0,
    CONS_TAG     = 3'd1,
    CONS_COMMENT = 3'd2,
    CONS_ANAME   = 3'd3,
    CONS_AVALUE  = 3'd4
  } cons_t;

  typedef enum logic {
    REC_SPAN = 1'b0,
    REC_EOL  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [COL_W-1:0]   start;
    logic [LEN_W-1:0]   len;
    cons_t              cons;
    mode_t              line_mode;
  } rec_t;

  // All records caused by one character; count is 1..RECS
  typedef struct packed {
    logic [RIDX_W-1:0]  count;
    rec_t [RECS-1:0]    recs;
  } bundle_t;

  typedef struct packed {
    logic     valid;
    bundle_t  data;
  } head_t;

  function automatic rec_t make_span(input logic [COL_W-1:0] b,
                                     input logic [COL_W-1:0] e,
                                     input cons_t c);
    rec_t r;
    r.kind      = REC_SPAN;
    r.start     = b;
    r.len       = (e >= b) ? ({1'b0, e - b} + LEN_W'(1)) : '0;
    r.cons      = c;
    r.line_mode = MD_NORMAL;
    return r;
  endfunction

  function automatic rec_t make_eol(input mode_t m);
    rec_t r;
    r.kind      = REC_EOL;
    r.start     = '0;
    r.len       = '0;
    r.cons      = CONS_ENTITY;
    r.line_mode = m;
    return r;
  endfunction

endpackage

// ===== design/hst_front.sv =====
// Front end: takes one character per cycle while q_full is low, runs the scan
// mode machine and emits a bundle of up to three records into the queue. Uses hst_pkg.
module hst_front import hst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CH_W-1:0]  ch,
  input  logic             end_of_line,
  input  logic             new_document,
  input  logic             push,
  input  logic             q_full,
  output logic             q_push,
  output bundle_t          q_data
);

  mode_t              scan_mode, scan_mode_next;
  logic [1:0]         comment_prefix_count, comment_prefix_count_next;
  logic               space_pending, space_pending_next;
  logic [COL_W-1:0]   column, column_next;
  logic [COL_W-1:0]   span_begin, span_begin_next;
  logic [COL_W-1:0]   space_col, space_col_next;
  logic [1:0]         dash_run, dash_run_next;
  logic               comment_stuck, comment_stuck_next;
  logic [CH_W-1:0]    quote_char, quote_char_next;

  logic               accept;
  logic [COL_W-1:0]   col, nxt, cmt_end;
  logic               done, fresh;
  logic [RIDX_W-1:0]  n;
  rec_t [RECS-1:0]    recs;
  cons_t              eol_cons;

  assign accept = push && !q_full;

  always_comb begin
    // fresh document drops any partly read line
    scan_mode_next            = new_document ? MD_NORMAL : scan_mode;
    comment_prefix_count_next = new_document ? 2'd0 : comment_prefix_count;
    space_pending_next        = new_document ? 1'b0 : space_pending;
    column_next               = new_document ? '0 : column;
    span_begin_next           = new_document ? '0 : span_begin;
    space_col_next            = new_document ? '0 : space_col;
    dash_run_next             = new_document ? 2'd0 : dash_run;
    comment_stuck_next        = new_document ? 1'b0 : comment_stuck;
    quote_char_next           = new_document ? '0 : quote_char;

    col      = column_next;
    nxt      = (col < COL_LAST) ? col + COL_W'(1) : col;
    cmt_end  = (col >= COL_W'(2)) ? col - COL_W'(2) : '0;
    done     = 1'b0;
    fresh    = 1'b0;
    n        = '0;
    recs     = '0;
    eol_cons = CONS_TAG;

    // space seen with the previous accepted character in a tag: decided by this character
    if (space_pending_next) begin
      space_pending_next = 1'b0;
      if (ch == CH_SLASH) begin
        done = 1'b1;
      end else begin
        recs[n]         = make_span(span_begin_next, space_col_next, CONS_TAG);
        n               = n + RIDX_W'(1);
        scan_mode_next  = MD_ANAME;
        span_begin_next = col;
      end
    end

    if (!done && scan_mode_next == MD_NORMAL) begin
      if (ch == CH_LT) begin
        scan_mode_next            = MD_PREFIX;
        comment_prefix_count_next = 2'd1;
        span_begin_next           = col;
      end else if (ch == CH_AMP) begin
        scan_mode_next  = MD_ENTITY;
        span_begin_next = col;
      end
      done = 1'b1;
    end

    if (!done && scan_mode_next == MD_ENTITY) begin
      if (ch == CH_SEMI) begin
        recs[n]        = make_span(span_begin_next, col, CONS_ENTITY);
        n              = n + RIDX_W'(1);
        scan_mode_next = MD_NORMAL;
      end
      done = 1'b1;
    end

    if (!done && scan_mode_next == MD_PREFIX) begin
      if (ch == ((comment_prefix_count_next == 2'd1) ? CH_BANG : CH_DASH)) begin
        if (comment_prefix_count_next == 2'd3) begin
          scan_mode_next            = MD_COMMENT;
          dash_run_next             = 2'd2;
          comment_prefix_count_next = 2'd0;
        end else begin
          comment_prefix_count_next = comment_prefix_count_next + 2'd1;
        end
        done = 1'b1;
      end else begin
        // not a comment opener: the same character is read as tag text
        scan_mode_next            = MD_TAG;
        comment_prefix_count_next = 2'd0;
      end
    end

    if (!done && scan_mode_next == MD_COMMENT) begin
      if (!comment_stuck_next) begin
        if (ch == CH_DASH) begin
          if (dash_run_next < 2'd2) dash_run_next = dash_run_next + 2'd1;
        end else if (ch == CH_GT && dash_run_next == 2'd2) begin
          dash_run_next = 2'd0;
          if (cmt_end == '0) begin
            // closer at the head of a continued line
            comment_stuck_next = 1'b1;
          end else begin
            recs[n].kind      = REC_SPAN;
            recs[n].start     = span_begin_next;
            recs[n].len       = (cmt_end > span_begin_next) ?
                                {1'b0, cmt_end - span_begin_next} : '0;
            recs[n].cons      = CONS_COMMENT;
            recs[n].line_mode = MD_NORMAL;
            n                 = n + RIDX_W'(1);
            scan_mode_next    = MD_NORMAL;
          end
        end else begin
          dash_run_next = 2'd0;
        end
      end
      done = 1'b1;
    end

    if (!done && scan_mode_next == MD_TAG) begin
      if (ch == CH_SPACE) begin
        if (end_of_line) begin
          recs[n]        = make_span(span_begin_next, col, CONS_TAG);
          n              = n + RIDX_W'(1);
          scan_mode_next = MD_ANAME;
          fresh          = 1'b1;
        end else begin
          space_pending_next = 1'b1;
          space_col_next     = col;
        end
      end else if (ch == CH_GT) begin
        recs[n]        = make_span(span_begin_next, col, CONS_TAG);
        n              = n + RIDX_W'(1);
        scan_mode_next = MD_NORMAL;
      end
      done = 1'b1;
    end

    if (!done && scan_mode_next == MD_ANAME) begin
      if (ch == CH_EQ) begin
        recs[n]         = make_span(span_begin_next, col, CONS_ANAME);
        n               = n + RIDX_W'(1);
        scan_mode_next  = MD_AVALUE;
        span_begin_next = nxt;
        quote_char_next = CH_NUL;
        fresh           = 1'b1;
      end
      done = 1'b1;
    end

    if (!done && scan_mode_next == MD_AVALUE) begin
      if (ch == quote_char_next) begin
        recs[n]         = make_span(span_begin_next, col, CONS_AVALUE);
        n               = n + RIDX_W'(1);
        scan_mode_next  = MD_TAG;
        span_begin_next = nxt;
        fresh           = 1'b1;
      end else if (quote_char_next == CH_NUL) begin
        quote_char_next = ch;
      end
    end

    if (end_of_line) begin
      if (scan_mode_next == MD_ENTITY) scan_mode_next = MD_NORMAL;
      if (scan_mode_next == MD_PREFIX) scan_mode_next = MD_TAG;
      unique case (scan_mode_next)
        MD_COMMENT: eol_cons = CONS_COMMENT;
        MD_TAG:     eol_cons = CONS_TAG;
        MD_ANAME:   eol_cons = CONS_ANAME;
        MD_AVALUE:  eol_cons = CONS_AVALUE;
        default:    eol_cons = CONS_TAG;
      endcase
      if (!fresh && scan_mode_next != MD_NORMAL) begin
        recs[n] = make_span(span_begin_next, col, eol_cons);
        n       = n + RIDX_W'(1);
      end
      recs[n] = make_eol(scan_mode_next);
      n       = n + RIDX_W'(1);
      comment_prefix_count_next = 2'd0;
      space_pending_next        = 1'b0;
      column_next               = '0;
      span_begin_next           = '0;
      space_col_next            = '0;
      dash_run_next             = 2'd0;
      comment_stuck_next        = 1'b0;
      quote_char_next           = '0;
    end else begin
      column_next = nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode            <= MD_NORMAL;
      comment_prefix_count <= 2'd0;
      space_pending        <= 1'b0;
      column               <= '0;
      span_begin           <= '0;
      space_col            <= '0;
      dash_run             <= 2'd0;
      comment_stuck        <= 1'b0;
      quote_char           <= '0;
    end else if (accept) begin
      scan_mode            <= scan_mode_next;
      comment_prefix_count <= comment_prefix_count_next;
      space_pending        <= space_pending_next;
      column               <= column_next;
      span_begin           <= span_begin_next;
      space_col            <= space_col_next;
      dash_run             <= dash_run_next;
      comment_stuck        <= comment_stuck_next;
      quote_char           <= quote_char_next;
    end
  end

  assign q_push       = accept && (n != '0);
  assign q_data.count = n;
  assign q_data.recs  = recs;

`ifndef SYNTHESIS
  a_eol_pushes: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_line |-> q_push)
    else $error("line end produced no records");

  a_eol_last: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_line |-> q_data.recs[n - RIDX_W'(1)].kind == REC_EOL)
    else $error("line end record is not the final record");

  a_space_line_clear: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_line |=> !space_pending && column == '0)
    else $error("line state not cleared at line end");
`endif

endmodule

// ===== design/hst_fifo.sv =====
// Short queue of record bundles between the front end and the back end.
// Uses hst_pkg.
module hst_fifo import hst_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  bundle_t  din,
  output logic     full,
  input  logic     pop,
  output head_t    head
);

  bundle_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wptr, rptr;
  logic [QPTR_W:0]     count;

  assign full       = (count == (QPTR_W+1)'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= wptr + QPTR_W'(1);
      if (pop && head.valid) rptr <= rptr + QPTR_W'(1);
      unique case ({push && !full, pop && head.valid})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("bundle pushed into full queue");
`endif

endmodule

// ===== design/hst_back.sv =====
// Back end: walks the records of the bundle at the queue head and hands
// them out one per pop, marking the final one. Uses hst_pkg.
module hst_back import hst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  head_t              head,
  output logic               head_pop,
  input  logic               pop,
  output logic               empty,
  output logic               record_kind,
  output logic [COL_W-1:0]   span_start,
  output logic [LEN_W-1:0]   span_length,
  output logic [2:0]         construct,
  output logic [2:0]         line_mode,
  output logic               last
);

  logic [RIDX_W-1:0]  sel, sel_next;
  rec_t               rec;

  assign empty       = !head.valid;
  assign rec         = head.data.recs[sel];
  assign last        = (sel == head.data.count - RIDX_W'(1));
  assign record_kind = rec.kind;
  assign span_start  = rec.start;
  assign span_length = rec.len;
  assign construct   = rec.cons;
  assign line_mode   = rec.line_mode;

  always_comb begin
    head_pop = 1'b0;
    sel_next = sel;
    if (pop && !empty) begin
      if (last) begin
        head_pop = 1'b1;
        sel_next = '0;
      end else begin
        sel_next = sel + RIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sel <= '0;
    else     sel <= sel_next;
  end

`ifndef SYNTHESIS
  a_sel_in_bundle: assert property (@(posedge clk) disable iff (rst)
    !empty |-> sel < head.data.count)
    else $error("record index beyond bundle");

  a_sel_idle_zero: assert property (@(posedge clk) disable iff (rst)
    empty |-> sel == '0)
    else $error("record index left over with empty queue");
`endif

endmodule

// ===== design/html_span_tokenizer.sv =====
// Channel   Handshake           Payload
// input     push / full         ch, end_of_line, new_document
// result    pop / empty         record_kind, span_start, span_length, construct,
//                               line_mode, last
//
// One character is accepted per cycle while full is low; its records
// (0 to 3) are registered into the queue. Results leave at one record per
// pop, so a stream that makes more than one record per character is paced
// by the result side. A 4-bundle queue separates the scanner from the record
// serializer; full rises only when that queue holds four bundles.
// rst is synchronous; after it the scan mode is normal and the queue empty.
// Top level of the HTML span tokenizer; uses hst_pkg, hst_front, hst_fifo, hst_back.
module html_span_tokenizer import hst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [CH_W-1:0]    ch,
  input  logic               end_of_line,
  input  logic               new_document,
  input  logic               push,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output logic               record_kind,
  output logic [COL_W-1:0]   span_start,
  output logic [LEN_W-1:0]   span_length,
  output logic [2:0]         construct,
  output logic [2:0]         line_mode,
  output logic               last
);

  logic     q_push, q_pop;
  bundle_t  q_data;
  head_t    q_head;

  hst_front u_front (
    .clk          (clk),
    .rst          (rst),
    .ch           (ch),
    .end_of_line  (end_of_line),
    .new_document (new_document),
    .push         (push),
    .q_full       (full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  hst_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_data),
    .full (full),
    .pop  (q_pop),
    .head (q_head)
  );

  hst_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .head_pop    (q_pop),
    .pop         (pop),
    .empty       (empty),
    .record_kind (record_kind),
    .span_start  (span_start),
    .span_length (span_length),
    .construct   (construct),
    .line_mode   (line_mode),
    .last        (last)
  );

endmodule
